FILE: design/rjdz_pkg.sv
package rjdz_pkg;

    // Register indexes of the configuration port.
    localparam int          CFG_IDX_W      = 2;
    localparam logic [1:0]  CFG_DEAD_ZONE  = 2'd0;
    localparam logic [1:0]  CFG_FULL_SCALE = 2'd1;

    // Register reset values.
    localparam logic [15:0] DEAD_ZONE_RST  = 16'd8000;
    localparam logic [15:0] FULL_SCALE_RST = 16'd30000;

    // Q1.15 one and the largest positive signed Q1.15 value.
    localparam logic [15:0] Q15_ONE        = 16'h8000;
    localparam logic [15:0] Q15_MAX_POS    = 16'h7FFF;

    // Quotient bits of the radial fraction below the clamp.
    localparam int          FRAC_STEPS     = 15;
    // Quotient bits of an axis scale.
    localparam int          SCALE_STEPS    = 16;

endpackage

FILE: design/rjdz_isqrt.sv
module rjdz_isqrt #(
    parameter int W      = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2*W-1:0]    in_radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [W-1:0]      out_root,
    output logic [SIDE_W-1:0] out_side
);

    // One root bit per stage, two radicand bits consumed per stage.
    logic              vld_reg  [0:W];
    logic [2*W-1:0]    rad_reg  [0:W];
    logic [W:0]        rem_reg  [0:W];
    logic [W-1:0]      root_reg [0:W];
    logic [SIDE_W-1:0] side_reg [0:W];

    // Stage zero is the item as it arrives.
    assign vld_reg[0]  = in_valid;
    assign rad_reg[0]  = in_radicand;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign side_reg[0] = in_side;

    for (genvar i = 0; i < W; i++) begin : g_step
        logic [W+2:0] trial_rem;
        logic [W+2:0] trial_sub;
        logic         fits;

        // Bring down two bits and try root*4+1.
        always_comb
        begin
            trial_rem = {rem_reg[i], rad_reg[i][2*W-1:2*W-2]};
            trial_sub = {1'b0, root_reg[i], 2'b01};
            fits      = (trial_rem >= trial_sub);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[i+1]  <= {rad_reg[i][2*W-3:0], 2'b00};
            rem_reg[i+1]  <= fits ? (W+1)'(trial_rem - trial_sub)
                                  : (W+1)'(trial_rem);
            root_reg[i+1] <= {root_reg[i][W-2:0], fits};
            side_reg[i+1] <= side_reg[i];
        end
    end

    assign out_valid = vld_reg[W];
    assign out_root  = root_reg[W];
    assign out_side  = side_reg[W];

endmodule

FILE: design/rjdz_frac.sv
module rjdz_frac #(
    parameter int W      = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [W-1:0]      in_len,
    input  logic [15:0]       dead_zone,
    input  logic [15:0]       full_scale,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [15:0]       out_frac,
    output logic              out_dead,
    output logic [SIDE_W-1:0] out_side
);
    import rjdz_pkg::*;

    localparam int CW = ((W > 16) ? W : 16) + 1;
    localparam int N  = FRAC_STEPS;

    logic              vld_reg  [0:N];
    logic [15:0]       rem_reg  [0:N];
    logic [15:0]       den_reg  [0:N];
    logic [N-1:0]      quo_reg  [0:N];
    logic              one_reg  [0:N];
    logic              dead_reg [0:N];
    logic [SIDE_W-1:0] side_reg [0:N];

    logic [CW-1:0] len_ext;
    logic [CW-1:0] dz_ext;
    logic [CW-1:0] num;
    logic [15:0]   den;
    logic          dead;
    logic          full;
    logic          sat;

    // Setup: dead test, numerator, denominator and clamp test.
    always_comb
    begin
        len_ext = CW'(in_len);
        dz_ext  = CW'(dead_zone);
        dead    = (len_ext < dz_ext);
        full    = (full_scale <= dead_zone);
        den     = full_scale - dead_zone;
        num     = len_ext - dz_ext;
        sat     = (num >= CW'(den));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num[15:0];
        den_reg[0]  <= den;
        quo_reg[0]  <= '0;
        one_reg[0]  <= full | sat;
        dead_reg[0] <= dead;
        side_reg[0] <= in_side;
    end

    // Restoring division, one quotient bit per stage.
    for (genvar k = 0; k < N; k++) begin : g_div
        logic [16:0] trial;
        logic        fits;

        always_comb
        begin
            trial = {rem_reg[k], 1'b0};
            fits  = (trial >= {1'b0, den_reg[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= fits ? 16'(trial - {1'b0, den_reg[k]}) : trial[15:0];
            den_reg[k+1]  <= den_reg[k];
            quo_reg[k+1]  <= {quo_reg[k][N-2:0], fits};
            one_reg[k+1]  <= one_reg[k];
            dead_reg[k+1] <= dead_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = vld_reg[N];
    assign out_frac  = one_reg[N] ? Q15_ONE : 16'(quo_reg[N]);
    assign out_dead  = dead_reg[N];
    assign out_side  = side_reg[N];

endmodule

FILE: design/rjdz_scale.sv
module rjdz_scale #(
    parameter int W      = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [W+15:0]     in_num,
    input  logic [W-1:0]      in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [15:0]       out_quo,
    output logic [SIDE_W-1:0] out_side
);
    import rjdz_pkg::*;

    localparam int N = SCALE_STEPS;

    logic              vld_reg  [0:N];
    logic [W-1:0]      rem_reg  [0:N];
    logic [N-1:0]      low_reg  [0:N];
    logic [W-1:0]      den_reg  [0:N];
    logic [N-1:0]      quo_reg  [0:N];
    logic [SIDE_W-1:0] side_reg [0:N];

    // The quotient fits 16 bits, so the upper numerator bits start as remainder.
    assign vld_reg[0]  = in_valid;
    assign rem_reg[0]  = in_num[W+15:16];
    assign low_reg[0]  = in_num[15:0];
    assign den_reg[0]  = in_den;
    assign quo_reg[0]  = '0;
    assign side_reg[0] = in_side;

    for (genvar k = 0; k < N; k++) begin : g_div
        logic [W:0] trial;
        logic       fits;

        always_comb
        begin
            trial = {rem_reg[k], low_reg[k][N-1]};
            fits  = (trial >= {1'b0, den_reg[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= fits ? W'(trial - {1'b0, den_reg[k]}) : trial[W-1:0];
            low_reg[k+1]  <= {low_reg[k][N-2:0], 1'b0};
            den_reg[k+1]  <= den_reg[k];
            quo_reg[k+1]  <= {quo_reg[k][N-2:0], fits};
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = vld_reg[N];
    assign out_quo   = quo_reg[N];
    assign out_side  = side_reg[N];

endmodule

FILE: design/radial_joystick_dead_zone_top.sv
// Radial dead zone for a two-axis stick. A sample is taken in every cycle in
// which start is high (busy is always low) and its result appears on done
// after passing the abs, squaring and sum registers, the bit-per-stage square
// root, the dead-zone fraction divider, the axis multiply register, the axis
// dividers and the output register. The receiver cannot stall; every result
// shows for one cycle. Write dead_zone and full_scale only while no sample is
// in flight.
module radial_joystick_dead_zone_top #(
    parameter int AXIS_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [AXIS_WIDTH-1:0]  axis_x,
    input  logic signed [AXIS_WIDTH-1:0]  axis_y,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rjdz_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    output logic                          done,
    output logic signed [15:0]            out_x,
    output logic signed [15:0]            out_y,
    output logic [15:0]                   magnitude,
    output logic                          in_dead
);
    import rjdz_pkg::*;

    localparam int W       = AXIS_WIDTH;
    localparam int LATENCY = W + 37;
    localparam int SQ_SIDE = 2*W + 2;
    localparam int FR_SIDE = 2*W + 2 + W;
    localparam int SX_SIDE = 1 + 1 + 1 + 16;

    logic [15:0] dead_zone_reg;
    logic [15:0] full_scale_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg  <= DEAD_ZONE_RST;
            full_scale_reg <= FULL_SCALE_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_DEAD_ZONE)
            begin
                dead_zone_reg <= cfg_data;
            end
            if (cfg_index == CFG_FULL_SCALE)
            begin
                full_scale_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // Front stages: absolute values, squares, sum.
    logic           s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [W-1:0]   s1_ax_reg, s1_ay_reg, s2_ax_reg, s2_ay_reg, s3_ax_reg, s3_ay_reg;
    logic           s1_nx_reg, s1_ny_reg, s2_nx_reg, s2_ny_reg, s3_nx_reg, s3_ny_reg;
    logic [2*W-1:0] s2_sqx_reg, s2_sqy_reg, s3_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_nx_reg  <= axis_x[W-1];
        s1_ny_reg  <= axis_y[W-1];
        s1_ax_reg  <= axis_x[W-1] ? W'(-axis_x) : W'(axis_x);
        s1_ay_reg  <= axis_y[W-1] ? W'(-axis_y) : W'(axis_y);
        s2_sqx_reg <= (2*W)'(s1_ax_reg) * (2*W)'(s1_ax_reg);
        s2_sqy_reg <= (2*W)'(s1_ay_reg) * (2*W)'(s1_ay_reg);
        s2_ax_reg  <= s1_ax_reg;
        s2_ay_reg  <= s1_ay_reg;
        s2_nx_reg  <= s1_nx_reg;
        s2_ny_reg  <= s1_ny_reg;
        s3_sum_reg <= s2_sqx_reg + s2_sqy_reg;
        s3_ax_reg  <= s2_ax_reg;
        s3_ay_reg  <= s2_ay_reg;
        s3_nx_reg  <= s2_nx_reg;
        s3_ny_reg  <= s2_ny_reg;
    end

    // Length.
    logic               sq_vld;
    logic [W-1:0]       sq_len;
    logic [SQ_SIDE-1:0] sq_side;

    rjdz_isqrt #(.W(W), .SIDE_W(SQ_SIDE)) u_isqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s3_vld_reg),
        .in_radicand (s3_sum_reg),
        .in_side     ({s3_ax_reg, s3_ay_reg, s3_nx_reg, s3_ny_reg}),
        .out_valid   (sq_vld),
        .out_root    (sq_len),
        .out_side    (sq_side)
    );

    // Radial fraction.
    logic               fr_vld;
    logic [15:0]        fr_frac;
    logic               fr_dead;
    logic [FR_SIDE-1:0] fr_side;

    rjdz_frac #(.W(W), .SIDE_W(FR_SIDE)) u_frac (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sq_vld),
        .in_len     (sq_len),
        .dead_zone  (dead_zone_reg),
        .full_scale (full_scale_reg),
        .in_side    ({sq_side, sq_len}),
        .out_valid  (fr_vld),
        .out_frac   (fr_frac),
        .out_dead   (fr_dead),
        .out_side   (fr_side)
    );

    logic [W-1:0] fr_ax, fr_ay, fr_len;
    logic         fr_nx, fr_ny;
    assign {fr_ax, fr_ay, fr_nx, fr_ny, fr_len} = fr_side;

    // Axis times fraction.
    logic          m_vld_reg;
    logic [W+15:0] m_px_reg, m_py_reg;
    logic [W-1:0]  m_len_reg;
    logic [15:0]   m_frac_reg;
    logic          m_nx_reg, m_ny_reg, m_dead_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= fr_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        m_px_reg   <= (W+16)'(fr_ax) * (W+16)'(fr_frac);
        m_py_reg   <= (W+16)'(fr_ay) * (W+16)'(fr_frac);
        m_len_reg  <= fr_len;
        m_frac_reg <= fr_frac;
        m_nx_reg   <= fr_nx;
        m_ny_reg   <= fr_ny;
        m_dead_reg <= fr_dead;
    end

    // Axis divisions by the length.
    logic               sx_vld, sy_vld;
    logic [15:0]        sx_quo, sy_quo;
    logic [SX_SIDE-1:0] sx_side;
    logic               sy_side;

    rjdz_scale #(.W(W), .SIDE_W(SX_SIDE)) u_scale_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_vld_reg),
        .in_num    (m_px_reg),
        .in_den    (m_len_reg),
        .in_side   ({m_nx_reg, m_dead_reg, (m_len_reg == '0), m_frac_reg}),
        .out_valid (sx_vld),
        .out_quo   (sx_quo),
        .out_side  (sx_side)
    );

    rjdz_scale #(.W(W), .SIDE_W(1)) u_scale_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m_vld_reg),
        .in_num    (m_py_reg),
        .in_den    (m_len_reg),
        .in_side   (m_ny_reg),
        .out_valid (sy_vld),
        .out_quo   (sy_quo),
        .out_side  (sy_side)
    );

    logic        sx_neg, sx_dead, sx_zero;
    logic [15:0] sx_frac;
    assign {sx_neg, sx_dead, sx_zero, sx_frac} = sx_side;

    // Sign and saturation; the special cases follow in the output register.
    logic [15:0] x_final, y_final;

    always_comb
    begin
        if (sx_neg)
        begin
            x_final = 16'd0 - sx_quo;
        end
        else
        begin
            x_final = (sx_quo > Q15_MAX_POS) ? Q15_MAX_POS : sx_quo;
        end
        if (sy_side)
        begin
            y_final = 16'd0 - sy_quo;
        end
        else
        begin
            y_final = (sy_quo > Q15_MAX_POS) ? Q15_MAX_POS : sy_quo;
        end
    end

    // Output register.
    logic        done_reg;
    logic [15:0] out_x_reg, out_y_reg, mag_reg;
    logic        dead_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sx_vld & sy_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        dead_out_reg <= sx_dead;
        mag_reg      <= sx_dead ? 16'd0 : sx_frac;
        out_x_reg    <= (sx_dead | sx_zero) ? 16'd0 : x_final;
        out_y_reg    <= (sx_dead | sx_zero) ? 16'd0 : y_final;
    end

    assign done      = done_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign magnitude = mag_reg;
    assign in_dead   = dead_out_reg;

    // Every result comes from an earlier sample on start.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching sample");

    // A result inside the dead zone is all zero.
    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_dead) |-> (out_x == 16'sd0 && out_y == 16'sd0 && magnitude == 16'd0))
        else $error("dead-zone result is not zero");

    // The fraction never exceeds one.
    a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (magnitude <= Q15_ONE))
        else $error("magnitude above one");

endmodule
